>>> rtl/core/rbfh_pkg.sv
// ----------------------------------------------------------------------------
// rbfh_pkg
// Shared types, constants and helpers for the ray/box face hit test.
// ----------------------------------------------------------------------------
package rbfh_pkg;

  localparam int FRAC_BITS = 16;
  localparam int AXES      = 3;
  localparam int WORD_W    = 32;
  localparam int QW        = 32;
  localparam int NUM_W     = WORD_W + 1 + FRAC_BITS;
  localparam int HI_W      = NUM_W - QW;
  localparam int DIV_LAT   = QW + 3;
  localparam int FACE_LAT  = 3;
  localparam int PIPE_LAT  = DIV_LAT + FACE_LAT + 2;

  localparam logic signed [WORD_W-1:0] SAT_MAX = 32'sh7fffffff;
  localparam logic signed [WORD_W-1:0] SAT_MIN = 32'sh80000000;
  localparam logic signed [63:0] P_MAX = 64'sh000000007fffffff;
  localparam logic signed [63:0] P_MIN = 64'shffffffff80000000;
  localparam logic [63:0] ROUND_BIAS = (64'd1 << FRAC_BITS) - 64'd1;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t st;
    word_t dr;
    word_t lo;
    word_t hi;
  } axis_t;

  typedef axis_t [AXES-1:0] item_t;

  function automatic word_t scale_sat(input logic signed [63:0] p);
    logic signed [63:0] b;
    logic signed [63:0] s;
    b = p + (p[63] ? ROUND_BIAS : 64'd0);
    s = b >>> FRAC_BITS;
    if (s > P_MAX) return SAT_MAX;
    if (s < P_MIN) return SAT_MIN;
    return s[WORD_W-1:0];
  endfunction

  function automatic logic in_range(input word_t st, input word_t pr, input word_t lo,
                                    input word_t hi);
    logic signed [WORD_W+1:0] pt;
    logic signed [WORD_W+1:0] l;
    logic signed [WORD_W+1:0] h;
    pt = $signed({{2{st[WORD_W-1]}}, st}) + $signed({{2{pr[WORD_W-1]}}, pr});
    l  = $signed({{2{lo[WORD_W-1]}}, lo});
    h  = $signed({{2{hi[WORD_W-1]}}, hi});
    return (pt >= l) && (pt <= h);
  endfunction

endpackage

>>> rtl/core/rbfh_div.sv
// ----------------------------------------------------------------------------
// rbfh_div
// Pipelined signed fixed-point divide t = ((plane - start) << FRAC) / dir,
// one quotient bit per stage, truncating toward zero, saturating to 32 bits.
// ----------------------------------------------------------------------------
module rbfh_div
  import rbfh_pkg::*;
(
  input  logic  clk,
  input  word_t plane,
  input  word_t st,
  input  word_t dr,
  output word_t t
);

  logic signed [WORD_W:0] diff;
  logic [WORD_W:0]        mag;
  logic [NUM_W-1:0]       num_r;
  logic [QW-1:0]          den_r;
  logic                   neg1_r;

  logic [QW:0]   rem_r [0:QW];
  logic [QW-1:0] n_r   [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic [QW-1:0] d_r   [0:QW];
  logic          neg_r [0:QW];
  logic          ovf_r [0:QW];
  logic [HI_W-1:0] hi_part;

  word_t t_r;

  assign diff = $signed({plane[WORD_W-1], plane}) - $signed({st[WORD_W-1], st});
  assign mag  = diff[WORD_W] ? (~diff + 1'b1) : diff;

  always_ff @(posedge clk) begin
    num_r  <= {mag, {FRAC_BITS{1'b0}}};
    den_r  <= dr[WORD_W-1] ? (~dr + 1'b1) : dr;
    neg1_r <= diff[WORD_W] ^ dr[WORD_W-1];
  end

  assign hi_part = num_r[NUM_W-1:QW];

  always_ff @(posedge clk) begin
    rem_r[0] <= (QW+1)'(hi_part);
    n_r[0]   <= num_r[QW-1:0];
    q_r[0]   <= '0;
    d_r[0]   <= den_r;
    neg_r[0] <= neg1_r;
    ovf_r[0] <= QW'(hi_part) >= den_r;
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [QW:0] trial;
    logic        ge;
    assign trial = {rem_r[i][QW-1:0], n_r[i][QW-1]};
    assign ge    = trial >= {1'b0, d_r[i]};
    always_ff @(posedge clk) begin
      rem_r[i+1] <= ge ? (trial - {1'b0, d_r[i]}) : trial;
      q_r[i+1]   <= {q_r[i][QW-2:0], ge};
      n_r[i+1]   <= {n_r[i][QW-2:0], 1'b0};
      d_r[i+1]   <= d_r[i];
      neg_r[i+1] <= neg_r[i];
      ovf_r[i+1] <= ovf_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (ovf_r[QW]) begin
      t_r <= neg_r[QW] ? SAT_MIN : SAT_MAX;
    end else if (!neg_r[QW]) begin
      t_r <= q_r[QW][QW-1] ? SAT_MAX : q_r[QW];
    end else begin
      t_r <= q_r[QW][QW-1] ? SAT_MIN : (~q_r[QW] + 1'b1);
    end
  end

  assign t = t_r;

endmodule

>>> rtl/core/rbfh_face.sv
// ----------------------------------------------------------------------------
// rbfh_face
// Per-face back end: project t onto the two other axes, scale, saturate and
// bound-check the hit point.
// ----------------------------------------------------------------------------
module rbfh_face
  import rbfh_pkg::*;
(
  input  logic  clk,
  input  word_t t,
  input  logic  skip,
  input  axis_t a0,
  input  axis_t a1,
  output logic  ok
);

  logic signed [63:0] prod0_r;
  logic signed [63:0] prod1_r;
  axis_t a0_1_r, a1_1_r, a0_2_r, a1_2_r;
  logic  skip1_r, skip2_r;
  word_t pr0_r, pr1_r;
  logic  ok_r;

  always_ff @(posedge clk) begin
    prod0_r <= $signed(t) * $signed(a0.dr);
    prod1_r <= $signed(t) * $signed(a1.dr);
    a0_1_r  <= a0;
    a1_1_r  <= a1;
    skip1_r <= skip;
  end

  always_ff @(posedge clk) begin
    pr0_r   <= scale_sat(prod0_r);
    pr1_r   <= scale_sat(prod1_r);
    a0_2_r  <= a0_1_r;
    a1_2_r  <= a1_1_r;
    skip2_r <= skip1_r;
  end

  always_ff @(posedge clk) begin
    ok_r <= !skip2_r
            && in_range(a0_2_r.st, pr0_r, a0_2_r.lo, a0_2_r.hi)
            && in_range(a1_2_r.st, pr1_r, a1_2_r.lo, a1_2_r.hi);
  end

  assign ok = ok_r;

endmodule

>>> rtl/core/ray_box_face_hit_test.sv
// ----------------------------------------------------------------------------
// ray_box_face_hit_test
// Ray line versus axis-aligned box face test in signed Q15.16.
// ----------------------------------------------------------------------------
// Takes one word per cycle (start high while busy is low) and returns out_hit
// with a one-cycle out_valid strobe for each accepted input word, in order,
// at a sustained rate of one word per clock. The pipeline is made of the input
// register, the six bit-serial divide pipelines (one quotient bit per stage)
// and the multiply, scale, bound-check and output stages. Results cannot be
// held off; busy is high only during reset.
module ray_box_face_hit_test
  import rbfh_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  output logic  busy,
  input  word_t in_start_x,
  input  word_t in_start_y,
  input  word_t in_start_z,
  input  word_t in_dir_x,
  input  word_t in_dir_y,
  input  word_t in_dir_z,
  input  word_t in_box_low_x,
  input  word_t in_box_low_y,
  input  word_t in_box_low_z,
  input  word_t in_box_high_x,
  input  word_t in_box_high_y,
  input  word_t in_box_high_z,
  output logic  out_valid,
  output logic  out_hit
);

  item_t in_item;
  item_t ctx_r [0:DIV_LAT];
  logic  cv_r  [0:DIV_LAT];
  logic  [FACE_LAT-1:0] fv_r;
  logic  [2*AXES-1:0] ok;
  logic  out_valid_r, out_hit_r;

  assign busy = !rst_n;

  assign in_item[0] = '{st: in_start_x, dr: in_dir_x, lo: in_box_low_x, hi: in_box_high_x};
  assign in_item[1] = '{st: in_start_y, dr: in_dir_y, lo: in_box_low_y, hi: in_box_high_y};
  assign in_item[2] = '{st: in_start_z, dr: in_dir_z, lo: in_box_low_z, hi: in_box_high_z};

  always_ff @(posedge clk) begin
    ctx_r[0] <= in_item;
    if (!rst_n) begin
      cv_r[0] <= 1'b0;
    end else begin
      cv_r[0] <= start && !busy;
    end
  end

  for (genvar i = 0; i < DIV_LAT; i++) begin : g_ctx
    always_ff @(posedge clk) begin
      ctx_r[i+1] <= ctx_r[i];
      if (!rst_n) begin
        cv_r[i+1] <= 1'b0;
      end else begin
        cv_r[i+1] <= cv_r[i];
      end
    end
  end

  for (genvar k = 0; k < AXES; k++) begin : g_axis
    for (genvar h = 0; h < 2; h++) begin : g_side
      word_t t;
      rbfh_div u_div (
        .clk   (clk),
        .plane (h ? ctx_r[0][k].hi : ctx_r[0][k].lo),
        .st    (ctx_r[0][k].st),
        .dr    (ctx_r[0][k].dr),
        .t     (t)
      );
      rbfh_face u_face (
        .clk  (clk),
        .t    (t),
        .skip (ctx_r[DIV_LAT][k].dr == '0),
        .a0   (ctx_r[DIV_LAT][(k+1)%AXES]),
        .a1   (ctx_r[DIV_LAT][(k+2)%AXES]),
        .ok   (ok[2*k+h])
      );
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fv_r        <= {fv_r[FACE_LAT-2:0], cv_r[DIV_LAT]};
      out_valid_r <= fv_r[FACE_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_hit_r <= |ok;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

endmodule

>>> rtl/core/rbfh_checker.sv
// ----------------------------------------------------------------------------
// rbfh_checker
// Port-level checks on the face hit test, bound to the top level.
// ----------------------------------------------------------------------------
module rbfh_checker
  import rbfh_pkg::*;
(
  input logic  clk,
  input logic  rst_n,
  input logic  start,
  input logic  busy,
  input word_t in_dir_x,
  input word_t in_dir_y,
  input word_t in_dir_z,
  input word_t in_box_low_x,
  input word_t in_box_low_y,
  input word_t in_box_low_z,
  input word_t in_box_high_x,
  input word_t in_box_high_y,
  input word_t in_box_high_z,
  input logic  out_valid,
  input logic  out_hit
);

  logic acc;
  logic zero_dir;
  logic inv_box;

  assign acc      = start && !busy;
  assign zero_dir = (in_dir_x == '0) && (in_dir_y == '0) && (in_dir_z == '0);
  assign inv_box  = ($signed(in_box_low_x) > $signed(in_box_high_x))
                 && ($signed(in_box_low_y) > $signed(in_box_high_y))
                 && ($signed(in_box_low_z) > $signed(in_box_high_z));

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid == $past(acc, PIPE_LAT))
    else $error("result strobe does not match accepted word");

  a_ready: assert property (@(posedge clk) rst_n |-> !busy)
    else $error("busy outside reset");

  a_zero_dir: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && zero_dir) |-> ##PIPE_LAT (out_valid && !out_hit))
    else $error("hit reported with zero direction");

  a_inv_box: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && inv_box) |-> ##PIPE_LAT (out_valid && !out_hit))
    else $error("hit reported on inverted box");

endmodule

bind ray_box_face_hit_test rbfh_checker u_rbfh_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .in_dir_x      (in_dir_x),
  .in_dir_y      (in_dir_y),
  .in_dir_z      (in_dir_z),
  .in_box_low_x  (in_box_low_x),
  .in_box_low_y  (in_box_low_y),
  .in_box_low_z  (in_box_low_z),
  .in_box_high_x (in_box_high_x),
  .in_box_high_y (in_box_high_y),
  .in_box_high_z (in_box_high_z),
  .out_valid     (out_valid),
  .out_hit       (out_hit)
);

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for ray_box_face_hit_test. A directed table of rays and
// boxes, then random rays, are fed under sender idling. Each out_hit strobe is
// compared in order with the row's given hit, else a hit predicted in the bench.
// ----------------------------------------------------------------------------
module tb;
  import rbfh_pkg::*;

  localparam int LIMIT = 400000;
  localparam int N_RAND = 1830;

  typedef struct {
    logic signed [31:0] st [3];
    logic signed [31:0] dr [3];
    logic signed [31:0] lo [3];
    logic signed [31:0] hi [3];
  } ray_box_t;

  typedef struct {
    ray_box_t rb;
    int       want;
  } row_t;

  logic  clk = 0;
  logic  rst_n = 0;
  logic  start = 0;
  logic  busy;
  word_t in_start_x = '0, in_start_y = '0, in_start_z = '0;
  word_t in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  word_t in_box_low_x = '0, in_box_low_y = '0, in_box_low_z = '0;
  word_t in_box_high_x = '0, in_box_high_y = '0, in_box_high_z = '0;
  logic  out_valid;
  logic  out_hit;

  logic  hit_q[$];
  int    errors = 0;
  int    cycles = 0;
  int    idle_pct = 26;

  ray_box_face_hit_test dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic signed [63:0] sat_word(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic face_hit(input ray_box_t r);
    logic signed [63:0] plane, t, prod, p;
    logic signed [63:0] one;
    logic ok;
    int j;
    one = 64'sd1 <<< FRAC_BITS;
    for (int k = 0; k < 3; k++) begin
      if (r.dr[k] == 0) continue;
      for (int h = 0; h < 2; h++) begin
        plane = h ? 64'(r.hi[k]) : 64'(r.lo[k]);
        t = sat_word(((plane - 64'(r.st[k])) * one) / 64'(r.dr[k]));
        ok = 1;
        for (int m = 1; m < 3; m++) begin
          j = (k + m) % 3;
          prod = sat_word((t * 64'(r.dr[j])) / one);
          p = 64'(r.st[j]) + prod;
          if (p < 64'(r.lo[j]) || p > 64'(r.hi[j])) ok = 0;
        end
        if (ok) return 1;
      end
    end
    return 0;
  endfunction

  task automatic report(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic logic signed [31:0] rnd_word();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'sh7fffffff - $urandom_range(0, 3);
      2: return 32'sh80000000 + $urandom_range(0, 3);
      3: return 0;
      default: return $signed($urandom_range(0, 32'h000a0000)) - 32'sh00050000;
    endcase
  endfunction

  function automatic ray_box_t rnd_ray();
    ray_box_t r;
    logic signed [31:0] a, b;
    for (int i = 0; i < 3; i++) begin
      r.st[i] = rnd_word();
      r.dr[i] = ($urandom_range(0, 7) == 0) ? 0 : rnd_word();
      a = rnd_word();
      b = rnd_word();
      if ($urandom_range(0, 9) != 0 && a > b) begin
        r.lo[i] = b; r.hi[i] = a;
      end else begin
        r.lo[i] = a; r.hi[i] = b;
      end
    end
    return r;
  endfunction

  function automatic ray_box_t mk(input int sx, sy, sz, dx, dy, dz, lx, ly, lz, hx, hy, hz);
    ray_box_t r;
    r.st = '{sx, sy, sz};
    r.dr = '{dx, dy, dz};
    r.lo = '{lx, ly, lz};
    r.hi = '{hx, hy, hz};
    return r;
  endfunction

  task automatic send(input ray_box_t r, input int want);
    logic h;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 0;
    end
    @(negedge clk);
    {in_start_x, in_start_y, in_start_z} <= {r.st[0], r.st[1], r.st[2]};
    {in_dir_x, in_dir_y, in_dir_z} <= {r.dr[0], r.dr[1], r.dr[2]};
    {in_box_low_x, in_box_low_y, in_box_low_z} <= {r.lo[0], r.lo[1], r.lo[2]};
    {in_box_high_x, in_box_high_y, in_box_high_z} <= {r.hi[0], r.hi[1], r.hi[2]};
    start <= 1;
    do @(posedge clk); while (busy);
    h = face_hit(r);
    if (want >= 0 && h !== want[0]) report("directed row disagrees with predictor");
    hit_q.push_back(want >= 0 ? want[0] : h);
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid) begin
      if (hit_q.size() == 0) report("hit word with none expected");
      else if (out_hit !== hit_q.pop_front()) report("out_hit wrong");
    end
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    int one;
    int wait_n;
    one = 1 << FRAC_BITS;
    // all directions zero, plain hit, miss, inverted box, ray in face plane
    rows.push_back('{mk(0, 0, 0, 0, 0, 0, -one, -one, -one, one, one, one), 0});
    rows.push_back('{mk(-5 * one, 0, 0, one, 0, 0, -one, -one, -one, one, one, one), 1});
    rows.push_back('{mk(-5 * one, 3 * one, 0, one, 0, 0, -one, -one, -one, one, one, one), 0});
    rows.push_back('{mk(-5 * one, 0, 0, one, 0, 0, -one, one, -one, one, -one, one), 0});
    rows.push_back('{mk(0, one, 0, 0, 0, one, -one, -one, -one, one, one, one), 1});
    rows.push_back('{mk(5 * one, 0, 0, one, 0, 0, -one, -one, -one, one, one, one), 1});
    rows.push_back('{mk(32'h80000000, 32'h80000000, 32'h80000000, 32'h7fffffff,
                        32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff), -1});
    rows.push_back('{mk(32'h7fffffff, 32'h80000000, 0, 32'h80000000, 1, 32'hffffffff,
                        32'h80000000, 0, 32'h80000000, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff), -1});
    rows.push_back('{mk(32'hffffffff, 32'hffffffff, 32'hffffffff, 1, 1, 1, 0, 0, 0,
                        32'hffffffff, 32'hffffffff, 32'hffffffff), -1});
    rows.push_back('{mk(0, 0, 0, 1, 32'h80000000, 32'h7fffffff, 32'h80000000,
                        32'h80000000, 32'h80000000, 0, 0, 0), -1});
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    foreach (rows[i]) send(rows[i].rb, rows[i].want);
    for (int i = 0; i < N_RAND; i++) begin
      if (i == N_RAND / 3) idle_pct = 83;
      if (i == 2 * N_RAND / 3) idle_pct = 0;
      send(rnd_ray(), -1);
    end
    @(negedge clk);
    start <= 0;
    wait_n = 0;
    while (hit_q.size() != 0 && wait_n < 10 * PIPE_LAT) begin
      @(posedge clk);
      wait_n++;
    end
    repeat (PIPE_LAT + 5) @(posedge clk);
    if (errors == 0 && hit_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
